// File: design/sliding_window_min_max_defines.svh
// assertion macros used by the checker file
`ifndef SLIDING_WINDOW_MIN_MAX_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SWMM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swmm assertion failed");

// next-cycle implication, disabled during reset
`define SWMM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swmm assertion failed");

`endif

// File: design/swmm_pkg.sv
`default_nettype none

package swmm_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CSR_W    = 6;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [CSR_W-1:0]           csr_type;

   // window length after reset
   localparam csr_type WINDOW_RESET = 6'd30;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic fill;
      logic write_new;
      logic scan;
      logic out_load;
   } swmm_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic cnt_last;
   } swmm_sts_type;

endpackage

`default_nettype wire

// File: design/swmm_ifs.sv
`default_nettype none

// sample channel
interface swmm_req_if import swmm_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// min and max channel
interface swmm_rsp_if import swmm_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type window_min;
   sample_type window_max;

   modport source (output valid, output window_min, output window_max, input ready);
   modport sink   (input valid, input window_min, input window_max, output ready);
endinterface

`default_nettype wire

// File: design/swmm_ram.sv
`default_nettype none

module swmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// File: design/swmm_datapath.sv
`default_nettype none

module swmm_datapath import swmm_pkg::*; #(
   parameter int MAX_WINDOW = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire csr_type      csr_wdata,
   input  wire sample_type   req_sample,
   input  wire swmm_cmd_type cmd,
   output swmm_sts_type      sts,
   output sample_type        rsp_window_min,
   output sample_type        rsp_window_max
);

   localparam int PTR_W = $clog2(MAX_WINDOW);

   typedef logic [PTR_W-1:0] ptr_type;

   csr_type    window_len_ff, window_len_in;
   ptr_type    ptr_ff, ptr_in;
   logic       rd_vld_ff, rd_vld_in;
   ptr_type    cnt_ff, cnt_in;
   ptr_type    len_m1_ff, len_m1_in;
   sample_type sample_ff, sample_in;
   sample_type lo_ff, lo_in;
   sample_type hi_ff, hi_in;
   sample_type min_out_ff, min_out_in;
   sample_type max_out_ff, max_out_in;

   ptr_type    len_m1;
   ptr_type    slot;
   ptr_type    slot_next;
   logic       ram_we;
   ptr_type    ram_waddr;
   sample_type ram_rdata;

   // effective length minus one: zero acts as one, clamp at the store depth
   always_comb begin
      if (window_len_ff == '0) begin
         len_m1 = '0;
      end else if (32'(window_len_ff) > MAX_WINDOW) begin
         len_m1 = PTR_W'(MAX_WINDOW - 1);
      end else begin
         len_m1 = PTR_W'(32'(window_len_ff) - 32'd1);
      end
   end

   // slot for the new sample and the pointer after it
   assign slot      = (ptr_ff > len_m1_ff) ? '0 : ptr_ff;
   assign slot_next = (slot == len_m1_ff) ? '0 : slot + 1'b1;

   assign sts.cnt_last = (cnt_ff == len_m1_ff);

   // window store
   assign ram_we    = cmd.fill | cmd.write_new;
   assign ram_waddr = cmd.fill ? cnt_ff : slot;

   swmm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WINDOW)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (sample_ff),
      .raddr (cnt_ff),
      .rdata (ram_rdata)
   );

   // next-state logic
   always_comb begin
      window_len_in = csr_we ? csr_wdata : window_len_ff;

      ptr_in = ptr_ff;
      if (cmd.fill && sts.cnt_last) begin
         ptr_in = '0;
      end else if (cmd.write_new) begin
         ptr_in = slot_next;
      end

      rd_vld_in = cmd.scan;

      cnt_in = cnt_ff;
      if (cmd.load) begin
         cnt_in = '0;
      end else if (cmd.fill || cmd.scan) begin
         cnt_in = cnt_ff + 1'b1;
      end

      len_m1_in = cmd.load ? len_m1 : len_m1_ff;
      sample_in = cmd.load ? req_sample : sample_ff;

      // running min and max, seeded with the new sample
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.load) begin
         lo_in = req_sample;
         hi_in = req_sample;
      end else if (rd_vld_ff) begin
         if (ram_rdata < lo_ff) begin
            lo_in = ram_rdata;
         end
         if (ram_rdata > hi_ff) begin
            hi_in = ram_rdata;
         end
      end

      min_out_in = cmd.out_load ? lo_ff : min_out_ff;
      max_out_in = cmd.out_load ? hi_ff : max_out_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WINDOW_RESET;
         ptr_ff        <= '0;
         rd_vld_ff     <= 1'b0;
      end else begin
         window_len_ff <= window_len_in;
         ptr_ff        <= ptr_in;
         rd_vld_ff     <= rd_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      len_m1_ff  <= len_m1_in;
      sample_ff  <= sample_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      min_out_ff <= min_out_in;
      max_out_ff <= max_out_in;
   end

   assign rsp_window_min = min_out_ff;
   assign rsp_window_max = max_out_ff;

endmodule

`default_nettype wire

// File: design/swmm_controller.sv
`default_nettype none

module swmm_controller import swmm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output swmm_cmd_type      cmd,
   input  wire swmm_sts_type sts
);

   typedef enum logic [2:0] {
      IDLE,
      FILL,
      WRITE,
      SCAN,
      DRAIN,
      DONE
   } state_type;

   state_type state_ff, state_in;
   logic      primed_ff, primed_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // sequencing and commands
   always_comb begin
      state_in  = state_ff;
      primed_in = primed_ff;
      cmd       = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = primed_ff ? WRITE : FILL;
            end
         end
         FILL: begin
            cmd.fill = 1'b1;
            if (sts.cnt_last) begin
               primed_in = 1'b1;
               state_in  = DONE;
            end
         end
         WRITE: begin
            cmd.write_new = 1'b1;
            state_in      = SCAN;
         end
         SCAN: begin
            cmd.scan = 1'b1;
            if (sts.cnt_last) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            state_in = DONE;
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: design/sliding_window_min_max.sv
// Sliding-window minimum and maximum over the most recent samples.
// req_ch carries one signed 16-bit sample per transaction; rsp_ch returns one
// transaction per sample with the window minimum and maximum, in order.
// csr_we/csr_wdata set the window length (1..MAX_WINDOW, 0 acts as 1, larger
// values clamp to MAX_WINDOW); write it only while no sample is in flight.
// The samples sit in a single-port-write RAM of MAX_WINDOW entries that is
// scanned one entry per cycle, so that memory port sets the rate.
// The first sample after reset fills all L slots and then loads the output
// register; later samples take one write, L reads, one read drain and one
// output load, L being the effective length.
// A new sample is accepted in the cycle after its predecessor's result is
// loaded into the output register, even while that result is still waiting.
// If rsp_ch stalls, the result is held and the block waits with the next
// result ready until the output register frees.
// Reset clears the pointer, the primed flag and the output valid, and sets the
// window length to 30; the store itself needs no clearing pass.
`default_nettype none

module sliding_window_min_max import swmm_pkg::*; #(
   parameter int MAX_WINDOW = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   swmm_req_if.sink    req_ch,
   swmm_rsp_if.source  rsp_ch,
   input  wire logic   csr_we,
   input  wire csr_type csr_wdata
);

   swmm_cmd_type cmd;
   swmm_sts_type sts;

   // sequencer
   swmm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // store, pointer and min/max scan
   swmm_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_sample     (req_ch.sample),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_window_min (rsp_ch.window_min),
      .rsp_window_max (rsp_ch.window_max)
   );

endmodule

`default_nettype wire

// File: design/swmm_checker.sv
`default_nettype none
`include "sliding_window_min_max_defines.svh"

module swmm_checker import swmm_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire sample_type rsp_window_min,
   input wire sample_type rsp_window_max
);

   // a stalled result keeps its payload
   `SWMM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_window_min) && $stable(rsp_window_max))

   // one sample at a time: no accept right after an accept
   `SWMM_ASSERT_NXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // the minimum never exceeds the maximum
   `SWMM_ASSERT_IMP(a_min_le_max, clock, reset, rsp_valid, rsp_window_min <= rsp_window_max)

   // no result straight out of reset
   `SWMM_ASSERT_IMP(a_reset_quiet, clock, reset, $past(reset), !rsp_valid)

endmodule

bind sliding_window_min_max swmm_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_window_min (rsp_ch.window_min),
   .rsp_window_max (rsp_ch.window_max)
);

`default_nettype wire
